@@ rtl/ffl_pkg.sv @@
// Shared types and constants for the first-fit free-list allocator.
`timescale 1ns / 1ps
package ffl_pkg;

  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int IN_W             = 12;
  localparam int FIELD_W          = 32;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_FREE_WR,
    S_WALK,
    S_RD_SIZE,
    S_RD_NEXT,
    S_CHECK,
    S_SPLIT_NB_SIZE,
    S_SPLIT_NB_NEXT,
    S_SPLIT_CUR_SIZE,
    S_SPLIT_CUR_NEXT,
    S_LINK,
    S_ADVANCE,
    S_PUT_ALLOC,
    S_PUT_FREE,
    S_PUT_FAIL
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_INIT,
    OP_ACCEPT,
    OP_FREE_WR,
    OP_RD_SIZE,
    OP_RD_NEXT,
    OP_SPLIT_NB_SIZE,
    OP_SPLIT_NB_NEXT,
    OP_SPLIT_CUR_SIZE,
    OP_SPLIT_CUR_NEXT,
    OP_LINK_PREV,
    OP_LINK_HEAD,
    OP_ADVANCE,
    OP_PUT_ALLOC,
    OP_PUT_FREE,
    OP_PUT_FAIL
  } dp_op_t;

  typedef struct packed {
    logic fe_done;
    logic clr_last;
    logic is_free;
    logic free_bad;
    logic walk_ok;
    logic fits;
    logic split;
    logic have_prev;
    logic out_full;
  } dp_status_t;

endpackage

@@ rtl/ffl_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module ffl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/ffl_ctrl.sv @@
// Controller state machine for the allocator: sequences clear, init, free, list walk, split and result output.
`timescale 1ns / 1ps
module ffl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffl_pkg::dp_status_t st,
  output ffl_pkg::dp_op_t    op
);
  import ffl_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:          if (st.clr_last) state_next = S_INIT;
      S_INIT:           if (st.fe_done) state_next = S_IDLE;
      S_IDLE:           if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (st.is_free) begin
          state_next = st.free_bad ? S_PUT_FAIL : S_FREE_WR;
        end else begin
          state_next = S_WALK;
        end
      end
      S_FREE_WR:        if (st.fe_done) state_next = S_PUT_FREE;
      S_WALK:           state_next = st.walk_ok ? S_RD_SIZE : S_PUT_FAIL;
      S_RD_SIZE:        if (st.fe_done) state_next = S_RD_NEXT;
      S_RD_NEXT:        if (st.fe_done) state_next = S_CHECK;
      S_CHECK: begin
        priority if (!st.fits) state_next = S_ADVANCE;
        else if (st.split)     state_next = S_SPLIT_NB_SIZE;
        else                   state_next = S_LINK;
      end
      S_SPLIT_NB_SIZE:  if (st.fe_done) state_next = S_SPLIT_NB_NEXT;
      S_SPLIT_NB_NEXT:  if (st.fe_done) state_next = S_SPLIT_CUR_SIZE;
      S_SPLIT_CUR_SIZE: if (st.fe_done) state_next = S_SPLIT_CUR_NEXT;
      S_SPLIT_CUR_NEXT: if (st.fe_done) state_next = S_LINK;
      S_LINK:           if (!st.have_prev || st.fe_done) state_next = S_PUT_ALLOC;
      S_ADVANCE:        state_next = S_WALK;
      S_PUT_ALLOC,
      S_PUT_FREE,
      S_PUT_FAIL:       if (!st.out_full) state_next = S_IDLE;
      default:          state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_CLEAR:          op = OP_CLEAR;
      S_INIT:           op = OP_INIT;
      S_IDLE:           if (in_valid) op = OP_ACCEPT;
      S_DISPATCH:       op = OP_NONE;
      S_FREE_WR:        op = OP_FREE_WR;
      S_WALK:           op = OP_NONE;
      S_RD_SIZE:        op = OP_RD_SIZE;
      S_RD_NEXT:        op = OP_RD_NEXT;
      S_CHECK:          op = OP_NONE;
      S_SPLIT_NB_SIZE:  op = OP_SPLIT_NB_SIZE;
      S_SPLIT_NB_NEXT:  op = OP_SPLIT_NB_NEXT;
      S_SPLIT_CUR_SIZE: op = OP_SPLIT_CUR_SIZE;
      S_SPLIT_CUR_NEXT: op = OP_SPLIT_CUR_NEXT;
      S_LINK:           op = st.have_prev ? OP_LINK_PREV : OP_LINK_HEAD;
      S_ADVANCE:        op = OP_ADVANCE;
      S_PUT_ALLOC:      if (!st.out_full) op = OP_PUT_ALLOC;
      S_PUT_FREE:       if (!st.out_full) op = OP_PUT_FREE;
      S_PUT_FAIL:       if (!st.out_full) op = OP_PUT_FAIL;
      default:          op = OP_NONE;
    endcase
  end

endmodule

@@ rtl/ffl_dp.sv @@
// Datapath for the allocator: list registers, field engine over the byte heap, output word.
`timescale 1ns / 1ps
module ffl_dp #(
  parameter int HEAP_BYTES   = ffl_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffl_pkg::HEADER_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ffl_pkg::dp_op_t          op,
  output ffl_pkg::dp_status_t      st,
  input  logic                     req_type,
  input  logic [ffl_pkg::IN_W-1:0] alloc_size,
  input  logic [ffl_pkg::IN_W-1:0] block_offset,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ffl_pkg::IN_W-1:0] payload_offset,
  output logic                     ok
);
  import ffl_pkg::*;

  localparam int FIELD_BYTES = HEADER_BYTES / 2;
  localparam int AW = $clog2(HEAP_BYTES);
  localparam int XW = ((AW > IN_W) ? AW : IN_W) + 2;
  localparam int NW = $clog2(HEAP_BYTES + 1);
  localparam int CW = $clog2(FIELD_BYTES + 1);
  localparam logic [FIELD_W-1:0] FMASK = (FIELD_BYTES >= 4) ? {FIELD_W{1'b1}} :
    FIELD_W'((64'd1 << (8 * FIELD_BYTES)) - 64'd1);

  logic [AW-1:0]      head, cur, prev, blk, clr_addr, link_off;
  logic               free_valid, have, have_prev, req_q;
  logic [NW-1:0]      n;
  logic [IN_W-1:0]    want, boff;
  logic [FIELD_W-1:0] csize, cnext, fld, fld_now, fe_val;
  logic [CW-1:0]      cnt;
  logic [1:0]         cap_idx;
  logic               cap, fe_read, fe_write, fe_done, link_ok;
  logic [XW-1:0]      nb, fe_base, acc_addr;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [7:0]         ram_wdata, ram_rdata;

  assign nb  = XW'(cur) + XW'(HEADER_BYTES) + XW'(want);
  assign blk = AW'(XW'(boff) - XW'(HEADER_BYTES));

  assign link_ok  = (cnext != '0) &&
                    ({2'b00, cnext} - 34'd1 + 34'(HEADER_BYTES) <= 34'(HEAP_BYTES));
  assign link_off = AW'(cnext - FIELD_W'(1));

  always_comb begin
    fe_read  = 1'b0;
    fe_write = 1'b0;
    fe_base  = '0;
    fe_val   = '0;
    unique case (op)
      OP_INIT: begin
        fe_write = 1'b1;
        fe_val   = FIELD_W'(HEAP_BYTES - HEADER_BYTES);
      end
      OP_FREE_WR: begin
        fe_write = 1'b1;
        fe_base  = XW'(blk) + XW'(FIELD_BYTES);
        fe_val   = free_valid ? FIELD_W'(head) + FIELD_W'(1) : '0;
      end
      OP_RD_SIZE: begin
        fe_read = 1'b1;
        fe_base = XW'(cur);
      end
      OP_RD_NEXT: begin
        fe_read = 1'b1;
        fe_base = XW'(cur) + XW'(FIELD_BYTES);
      end
      OP_SPLIT_NB_SIZE: begin
        fe_write = 1'b1;
        fe_base  = nb;
        fe_val   = csize - FIELD_W'(want) - FIELD_W'(HEADER_BYTES);
      end
      OP_SPLIT_NB_NEXT: begin
        fe_write = 1'b1;
        fe_base  = nb + XW'(FIELD_BYTES);
        fe_val   = cnext;
      end
      OP_SPLIT_CUR_SIZE: begin
        fe_write = 1'b1;
        fe_base  = XW'(cur);
        fe_val   = FIELD_W'(want);
      end
      OP_SPLIT_CUR_NEXT: begin
        fe_write = 1'b1;
        fe_base  = XW'(cur) + XW'(FIELD_BYTES);
        fe_val   = FIELD_W'(nb) + FIELD_W'(1);
      end
      OP_LINK_PREV: begin
        fe_write = 1'b1;
        fe_base  = XW'(prev) + XW'(FIELD_BYTES);
        fe_val   = cnext;
      end
      default: begin
        fe_read  = 1'b0;
        fe_write = 1'b0;
      end
    endcase
  end

  assign fe_done  = (fe_write && cnt == CW'(FIELD_BYTES - 1)) ||
                    (fe_read && cnt == CW'(FIELD_BYTES));
  assign acc_addr = fe_base + XW'(cnt);
  assign cap      = fe_read && (cnt != '0) && (cnt <= CW'(4));
  assign cap_idx  = 2'(cnt - CW'(1));

  always_comb begin
    fld_now = (cnt == '0) ? '0 : fld;
    if (cap) begin
      fld_now[8*cap_idx +: 8] = ram_rdata;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = acc_addr[AW-1:0];
    ram_wdata = '0;
    priority if (op == OP_CLEAR) begin
      ram_we   = 1'b1;
      ram_addr = clr_addr;
    end else if (fe_write) begin
      ram_we = (acc_addr < XW'(HEAP_BYTES));
      if (cnt < CW'(4)) begin
        ram_wdata = fe_val[8*cnt[1:0] +: 8];
      end
    end else begin
      ram_we = 1'b0;
    end
  end

  ffl_ram #(
    .WIDTH(8),
    .DEPTH(HEAP_BYTES)
  ) u_heap (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      free_valid <= 1'b1;
      clr_addr   <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (op == OP_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (fe_read || fe_write) begin
        cnt <= fe_done ? '0 : cnt + CW'(1);
      end
      if (op == OP_FREE_WR && fe_done) begin
        head       <= blk;
        free_valid <= 1'b1;
      end
      if (op == OP_LINK_HEAD) begin
        free_valid <= link_ok;
        head       <= link_ok ? link_off : '0;
      end
      if (op == OP_PUT_ALLOC || op == OP_PUT_FREE || op == OP_PUT_FAIL) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fe_read) begin
      fld <= fld_now;
    end
    unique case (op)
      OP_ACCEPT: begin
        req_q     <= req_type;
        want      <= alloc_size;
        boff      <= block_offset;
        cur       <= head;
        have      <= free_valid;
        have_prev <= 1'b0;
        n         <= '0;
      end
      OP_RD_SIZE:        if (fe_done) csize <= fld_now;
      OP_RD_NEXT:        if (fe_done) cnext <= fld_now;
      OP_SPLIT_CUR_NEXT: if (fe_done) cnext <= (FIELD_W'(nb) + FIELD_W'(1)) & FMASK;
      OP_ADVANCE: begin
        prev      <= cur;
        have_prev <= 1'b1;
        n         <= n + NW'(1);
        have      <= link_ok;
        if (link_ok) begin
          cur <= link_off;
        end
      end
      OP_PUT_ALLOC: begin
        payload_offset <= IN_W'(XW'(cur) + XW'(HEADER_BYTES));
        ok             <= 1'b1;
      end
      OP_PUT_FREE: begin
        payload_offset <= '0;
        ok             <= 1'b1;
      end
      OP_PUT_FAIL: begin
        payload_offset <= '0;
        ok             <= 1'b0;
      end
      default: begin
        n <= n;
      end
    endcase
  end

  always_comb begin
    st.fe_done   = fe_done;
    st.clr_last  = (clr_addr == AW'(HEAP_BYTES - 1));
    st.is_free   = req_q;
    st.free_bad  = !((boff >= IN_W'(HEADER_BYTES)) && (XW'(boff) <= XW'(HEAP_BYTES)));
    st.walk_ok   = have && (n != NW'(HEAP_BYTES));
    st.fits      = (csize >= FIELD_W'(want));
    st.split     = ({1'b0, csize} > (33'(want) + 33'(HEADER_BYTES)));
    st.have_prev = have_prev;
    st.out_full  = out_valid && out_stall;
  end

endmodule

@@ rtl/first_fit_free_list_allocator.sv @@
// First-fit free-list heap allocator, top level.
// Usage: one request word enters on in_valid/in_stall (req_type, alloc_size,
// block_offset); one result word leaves on out_valid/out_stall
// (payload_offset, ok). A word moves when valid is high and stall is low.
// The heap is one byte-wide RAM with one port; headers hold a size and a
// next field of HEADER_BYTES/2 bytes each, read and written one byte a cycle.
// After reset the block sweeps the heap to zero, writes the size field of the
// first header and holds in_stall high meanwhile. A free writes the block's
// next field and puts the block at the head of the list (an out-of-range
// offset fails instead); an allocate walks the list, reading each node's size
// and next field, splits a block larger than needed and unlinks the one taken.
// One request is worked at a time; the byte-serial heap port sets the pace.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls and a second result is ready, the
// block holds that result and stalls its input until the register frees.
`timescale 1ns / 1ps
module first_fit_free_list_allocator #(
  parameter int HEAP_BYTES   = ffl_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffl_pkg::HEADER_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic [ffl_pkg::IN_W-1:0] alloc_size,
  input  logic [ffl_pkg::IN_W-1:0] block_offset,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ffl_pkg::IN_W-1:0] payload_offset,
  output logic                     ok
);
  import ffl_pkg::*;

  dp_op_t     op;
  dp_status_t st;

  ffl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .op      (op)
  );

  ffl_dp #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .st            (st),
    .req_type      (req_type),
    .alloc_size    (alloc_size),
    .block_offset  (block_offset),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_offset(payload_offset),
    .ok            (ok)
  );

endmodule

@@ rtl/ffl_checker.sv @@
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
module ffl_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     req_type,
  input logic [ffl_pkg::IN_W-1:0] alloc_size,
  input logic [ffl_pkg::IN_W-1:0] block_offset,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [ffl_pkg::IN_W-1:0] payload_offset,
  input logic                     ok
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload_offset) && $stable(ok))
    else $error("stalled output word changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> payload_offset == '0)
    else $error("failed result carries an offset");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("reset did not clear output or stall input");

  a_in_after_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still in work");

endmodule

bind first_fit_free_list_allocator ffl_checker u_ffl_checker (.*);
